### design/itda_pkg.sv
`timescale 1ns / 1ps

package itda_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // Control shared by every digit cell
    typedef struct packed {
        logic clear;    // zero the digit
        logic dabble;   // add-3 correction, then shift one bit in
        logic advance;  // take the digit of the less significant neighbor
    } itda_cell_ctrl_t;

endpackage

### design/itda_bcd_cell.sv
`timescale 1ns / 1ps

module itda_bcd_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  itda_pkg::itda_cell_ctrl_t ctrl,
    input  logic                      bit_in,     // from less significant neighbor
    input  logic [3:0]                digit_in,   // from less significant neighbor
    output logic                      carry_out,  // to more significant neighbor
    output logic [3:0]                digit
);
    import itda_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // double dabble correction: a digit of 5 or more becomes >= 8 before the shift
    assign adj       = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else if (ctrl.advance)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

### design/int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Steps: load the value, shift it MSB first into the BCD cell row one bit per cycle,
// emit the sign if negative, then walk the digit row (leading zeros skipped without output).
// A new value is accepted only in idle, once the last character of the previous one
// has been registered at the output.
// Reset: rst_n asynchronous, active low; returns to idle with no result pending.
module int_to_decimal_ascii
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: value [VALUE_WIDTH-1:0], zero padded to whole bytes
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8)*8-1:0] s_tdata,
    // m_tdata: character [7:0]; m_tlast: is_last
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,
    output logic                                 m_tlast
);
    import itda_pkg::*;

    // decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1)
    localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_W = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DIG_W-1:0]       left_reg, left_next;   // digits still in the row
    logic                   lead_reg, lead_next;   // still skipping leading zeros
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [7:0]             m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;

    logic                   accept;
    logic                   out_free;
    logic [VALUE_WIDTH-1:0] raw;
    logic                   last_dig;
    logic [3:0]             top_digit;
    itda_cell_ctrl_t        ctrl;

    logic [3:0]             digit_q [NDIG];
    logic                   carry   [NDIG-1];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign raw       = s_tdata[VALUE_WIDTH-1:0];
    assign top_digit = digit_q[NDIG-1];
    assign last_dig  = (left_reg == DIG_W'(1));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Row of BCD cells, cell 0 least significant. During conversion the
    // magnitude enters cell 0 MSB first; during output the digits move up
    // one cell a cycle unless output back-pressure holds them, and the top cell is read.
    for (genvar i = 0; i < NDIG; i++)
    begin : g_cell
        logic       bit_in;
        logic [3:0] digit_in;

        if (i == 0)
        begin : g_first
            assign bit_in   = mag_reg[VALUE_WIDTH-1];
            assign digit_in = 4'd0;
        end
        else
        begin : g_rest
            assign bit_in   = carry[i-1];
            assign digit_in = digit_q[i-1];
        end

        if (i < NDIG - 1)
        begin : g_mid
            itda_bcd_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .bit_in    (bit_in),
                .digit_in  (digit_in),
                .carry_out (carry[i]),
                .digit     (digit_q[i])
            );
        end
        else
        begin : g_top
            // top cell never overflows for an in-range magnitude
            itda_bcd_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .bit_in    (bit_in),
                .digit_in  (digit_in),
                .carry_out (),
                .digit     (digit_q[i])
            );
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        left_next     = left_reg;
        lead_next     = lead_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        ctrl          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = raw[VALUE_WIDTH-1];
                    // two's complement magnitude; the most negative value maps to 2^(W-1)
                    mag_next   = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
                    cnt_next   = CNT_W'(VALUE_WIDTH);
                    ctrl.clear = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                ctrl.dabble = 1'b1;
                mag_next    = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next    = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    left_next  = DIG_W'(NDIG);
                    lead_next  = 1'b1;
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (!neg_reg)
                begin
                    state_next = ST_EMIT;
                end
                else if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = ASCII_MINUS;
                    m_tlast_next  = 1'b0;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (lead_reg && (top_digit == 4'd0) && !last_dig)
                begin
                    // leading zero: drop it
                    ctrl.advance = 1'b1;
                    left_next    = left_reg - DIG_W'(1);
                end
                else if (out_free)
                begin
                    ctrl.advance  = 1'b1;
                    left_next     = left_reg - DIG_W'(1);
                    lead_next     = 1'b0;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = ASCII_ZERO + {4'd0, top_digit};
                    m_tlast_next  = last_dig;
                    if (last_dig)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            left_reg     <= '0;
            lead_reg     <= 1'b0;
            neg_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            left_reg     <= left_next;
            lead_reg     <= lead_next;
            neg_reg      <= neg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

### tb/tb_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

module tb_int_to_decimal_ascii;

    import itda_pkg::*;

    localparam int VALUE_WIDTH = 32;
    localparam int DATA_W      = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 138;
    // Cycles with no item accepted on either side before the run is abandoned.
    // The margin covers one conversion and long random stalls.
    localparam int STALL_LIMIT = 2000;
    // Quiet cycles after the last character, well beyond one conversion.
    localparam int TAIL_CYCLES = 100;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;     // value [31:0]
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;     // character [7:0]
    logic              m_tlast;     // is_last

    // Expected text of every accepted value, one character per entry,
    // oldest first. Characters from consecutive values simply follow on.
    class decimal_text_board;
        logic [7:0] exp_char[$];
        logic       exp_last[$];
        int         mismatches;
        int         chars_checked;

        function new();
            mismatches    = 0;
            chars_checked = 0;
        endfunction

        function int pending();
            return exp_char.size();
        endfunction

        // Queue the decimal text of one accepted value.
        function void note_value(logic [VALUE_WIDTH-1:0] value);
            logic [VALUE_WIDTH-1:0] mag;
            logic [VALUE_WIDTH-1:0] rem;
            logic [7:0]             digits[$];
            bit                     neg;
            neg = value[VALUE_WIDTH-1];
            // two's complement magnitude; the most negative value stays exact
            // because the result is read as unsigned
            mag = neg ? (~value + 1'b1) : value;
            do
            begin
                rem = mag % 10;
                digits.push_front(ASCII_ZERO + rem[7:0]);
                mag = mag / 10;
            end
            while (mag != 0);
            if (neg)
            begin
                exp_char.push_back(ASCII_MINUS);
                exp_last.push_back(1'b0);
            end
            foreach (digits[i])
            begin
                exp_char.push_back(digits[i]);
                exp_last.push_back(i == digits.size() - 1);
            end
        endfunction

        // Compare one delivered character with the oldest expectation.
        function void check_char(logic [7:0] ch, logic last);
            logic [7:0] want_ch;
            logic       want_last;
            chars_checked++;
            if (exp_char.size() == 0)
            begin
                $display("%0t: unexpected character, expected none, got 0x%02h last=%b",
                         $time, ch, last);
                mismatches++;
                return;
            end
            want_ch   = exp_char.pop_front();
            want_last = exp_last.pop_front();
            if (ch !== want_ch)
            begin
                $display("%0t: character mismatch, expected 0x%02h, got 0x%02h",
                         $time, want_ch, ch);
                mismatches++;
            end
            if (last !== want_last)
            begin
                $display("%0t: tlast mismatch on 0x%02h, expected %b, got %b",
                         $time, want_ch, want_last, last);
                mismatches++;
            end
        endfunction
    endclass

    decimal_text_board board;
    bit                no_idle;
    int                values_sent;
    int                negatives_sent;
    int                stall_cycles;

    int_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Idle with a chance of about 35 in 100, unless a no-idle stretch is running.
    function automatic bit take_break();
        return !no_idle && ($urandom_range(99) < 35);
    endfunction

    // Random value with a spread of digit counts, signs and boundary cases.
    function automatic logic [31:0] pick_value();
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;
        int          ndig;
        logic [31:0] v;
        ndig = $urandom_range(10, 1);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = (ndig == 10) ? 32'd2147483647 : lo * 10 - 1;
        if (ndig == 1)
            lo = 0;
        case ($urandom_range(3))
            0:       v = $urandom();                 // all bits random
            1, 2:    v = $urandom_range(hi, lo);     // exactly ndig digits
            default:
            begin
                // around a power of ten, or at the most negative value
                mag = $urandom_range(9) == 0 ? 32'h8000_0000 : lo + $urandom_range(2) - 1;
                v = mag;
            end
        endcase
        if ($urandom_range(1) == 1 && v != 32'h8000_0000)
            v = ~v + 1'b1;
        return v;
    endfunction

    // Present one value and hold it until accepted. Valid stays high on
    // return so a following value can go out back to back.
    task automatic send_value(input logic [31:0] v);
        @(negedge clk);
        while (take_break())
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_value(v);
        values_sent++;
        if (v[31])
            negatives_sent++;
    endtask

    task automatic release_bus();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Sink side: random back-pressure, check on each accepted character.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready <= !take_break();
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_char(m_tdata, m_tlast);
        end
    end

    // Watchdog on cycles where neither side moves an item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        board          = new();
        no_idle        = 1'b0;
        values_sent    = 0;
        negatives_sent = 0;
        stall_cycles   = 0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero, single digits, several digit count boundaries,
        // both extremes including the most negative value, alternating bits.
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'd99);
        send_value(32'd100);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h8000_0001);
        send_value(32'd1000000000);
        send_value(32'd999999999);
        send_value(-32'sd999999999);
        send_value(32'd123456789);
        send_value(-32'sd5);
        send_value(32'h5555_5555);
        send_value(32'hAAAA_AAAA);
        send_value(32'd1000);
        send_value(-32'sd1000000);
        send_value(32'hFFFF_FFFE);
        send_value(32'd7);

        // Sender holds off until every character has come out.
        release_bus();
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // a stretch with no idling on either side
            no_idle = (n >= 60 && n < 100);
            if (n == 120)
            begin
                release_bus();
                wait_drained();
            end
            send_value(pick_value());
        end
        no_idle = 1'b0;
        release_bus();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d values (%0d negative), %0d characters checked.",
                 values_sent, negatives_sent, board.chars_checked);
        $display("Included zero, both extremes, every digit count and random stalls.");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
